@@ rtl/vv_pkg.sv @@
// Package for the velocity Verlet particle update core.
// Holds fixed-point widths, pipeline depths and register indexes shared by all modules.
package vv_pkg;
	localparam int FRAC_BITS   = 16;
	localparam int POS_W       = 31;
	localparam int VAL_W       = 32;
	localparam int PROD_W      = 63;
	localparam int DIV_W       = 33;
	localparam int DIV_STAGES  = 33;
	localparam int LANE_LAT    = DIV_STAGES + 6;
	localparam int CFG_W       = 31;
	localparam int NUM_LANES   = 3;

	localparam logic REG_TIME_STEP  = 1'b0;
	localparam logic REG_BOX_LENGTH = 1'b1;

	localparam logic [CFG_W-1:0] TIME_STEP_RST  = 31'd655;
	localparam logic [CFG_W-1:0] BOX_LENGTH_RST = 31'd655360;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] vel;
		logic             neg;
		logic             ovf;
		logic             qzero;
		logic             mode;
	} vv_side_t;
endpackage

@@ rtl/vv_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Depends on vv_pkg; quotient is valid only when it fits in DIV_W bits.
module vv_div import vv_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [PROD_W-1:0] dividend,
	input  logic [DIV_W-1:0]  divisor,
	output logic [DIV_W-1:0]  quotient
);
	logic [PROD_W-1:0] rem_s [0:DIV_STAGES];
	logic [DIV_W-1:0]  dsr_s [0:DIV_STAGES];
	logic [DIV_W-1:0]  quo_s [0:DIV_STAGES];

	assign rem_s[0] = dividend;
	assign dsr_s[0] = divisor;
	assign quo_s[0] = '0;

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
		localparam int SH = DIV_STAGES - 1 - i;
		logic [PROD_W+2:0] trial;
		assign trial = {3'b000, rem_s[i]} - ({{(PROD_W+3-DIV_W){1'b0}}, dsr_s[i]} << SH);
		always_ff @(posedge clk) begin
			if (en) begin
				dsr_s[i+1] <= dsr_s[i];
				if (!trial[PROD_W+2]) begin
					rem_s[i+1] <= trial[PROD_W-1:0];
					quo_s[i+1] <= {quo_s[i][DIV_W-2:0], 1'b1};
				end else begin
					rem_s[i+1] <= rem_s[i];
					quo_s[i+1] <= {quo_s[i][DIV_W-2:0], 1'b0};
				end
			end
		end
	end

	assign quotient = quo_s[DIV_STAGES];
endmodule

@@ rtl/vv_lane.sv @@
// One coordinate lane: half kick with saturation, drift and single periodic wrap.
// Depends on vv_pkg and vv_div. With mode set, drift and wrap are skipped.
module vv_lane import vv_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [CFG_W-1:0]  time_step,
	input  logic [CFG_W-1:0]  box_length,
	input  logic              mode,
	input  logic [POS_W-1:0]  pos,
	input  logic [VAL_W-1:0]  vel,
	input  logic [VAL_W-1:0]  frc,
	input  logic [VAL_W-1:0]  mass,
	output logic [POS_W-1:0]  new_pos,
	output logic [VAL_W-1:0]  new_vel
);
	logic [POS_W-1:0]  pos_s1, pos_s2, pos_s3, pos_s5;
	logic [VAL_W-1:0]  vel_s1, vel_s2, vel_s3, force_s1, mass_s1, vel_s4, vel_s5;
	logic              mode_s1, mode_s2, mode_s3, mode_s4, mode_s5, neg_s2, neg_s3;
	logic              mz_s2, ovf_s3, qz_s3, vneg_s5;
	logic [PROD_W-1:0] prod_s2, prod_s3, acc_s5;
	logic [DIV_W-1:0]  dsr_s2, dsr_s3, quo;
	logic [POS_W-1:0]  pos_s4;
	logic [VAL_W-1:0]  fmag, vmag;
	vv_side_t          dl_q [0:DIV_STAGES-1];
	vv_side_t          side;
	logic [DIV_W+1:0]  qext, sum;
	logic [PROD_W:0]   acc_rnd;
	logic [PROD_W-FRAC_BITS:0] step_up, step_dn;
	logic [PROD_W-FRAC_BITS+2:0] app, app_w;

	assign fmag = force_s1[VAL_W-1] ? (~force_s1 + 1'b1) : force_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1 <= pos; vel_s1 <= vel; force_s1 <= frc; mass_s1 <= mass; mode_s1 <= mode;
			prod_s2 <= {{(PROD_W-CFG_W){1'b0}}, time_step} * {{(PROD_W-VAL_W){1'b0}}, fmag};
			dsr_s2 <= {mass_s1, 1'b0};
			mz_s2 <= (mass_s1 == '0);
			neg_s2 <= force_s1[VAL_W-1];
			pos_s2 <= pos_s1; vel_s2 <= vel_s1; mode_s2 <= mode_s1;
			prod_s3 <= prod_s2; dsr_s3 <= dsr_s2;
			ovf_s3 <= mz_s2 ? (prod_s2 != '0)
				: ({3'b000, prod_s2[PROD_W-1:DIV_W]} >= dsr_s2);
			qz_s3 <= mz_s2;
			neg_s3 <= neg_s2; pos_s3 <= pos_s2; vel_s3 <= vel_s2; mode_s3 <= mode_s2;
		end
	end

	vv_div u_div (
		.clk(clk), .en(en), .dividend(prod_s3), .divisor(dsr_s3), .quotient(quo)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			dl_q[0] <= '{pos: pos_s3, vel: vel_s3, neg: neg_s3, ovf: ovf_s3,
				qzero: qz_s3, mode: mode_s3};
			for (int i = 1; i < DIV_STAGES; i++) dl_q[i] <= dl_q[i-1];
		end
	end

	assign side = dl_q[DIV_STAGES-1];
	assign qext = side.qzero ? '0 : {1'b0, 1'b0, quo};
	assign sum  = {{3{side.vel[VAL_W-1]}}, side.vel} + (side.neg ? (~qext + 1'b1) : qext);

	always_ff @(posedge clk) begin
		if (en) begin
			if (side.ovf)
				vel_s4 <= side.neg ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
			else if (sum[DIV_W+1] && !(&sum[DIV_W:VAL_W-1]))
				vel_s4 <= {1'b1, {(VAL_W-1){1'b0}}};
			else if (!sum[DIV_W+1] && (|sum[DIV_W:VAL_W-1]))
				vel_s4 <= {1'b0, {(VAL_W-1){1'b1}}};
			else
				vel_s4 <= sum[VAL_W-1:0];
			pos_s4 <= side.pos; mode_s4 <= side.mode;
		end
	end

	assign vmag = vel_s4[VAL_W-1] ? (~vel_s4 + 1'b1) : vel_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s5 <= {{(PROD_W-CFG_W){1'b0}}, time_step} * {{(PROD_W-VAL_W){1'b0}}, vmag};
			vneg_s5 <= vel_s4[VAL_W-1];
			vel_s5 <= vel_s4; pos_s5 <= pos_s4; mode_s5 <= mode_s4;
		end
	end

	assign step_up = {1'b0, acc_s5[PROD_W-1:FRAC_BITS]};
	assign acc_rnd = {1'b0, acc_s5} + {{(PROD_W+1-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
	assign step_dn = acc_rnd[PROD_W:FRAC_BITS];
	assign app = {{(PROD_W-FRAC_BITS+3-POS_W){1'b0}}, pos_s5}
		+ (vneg_s5 ? (~{2'b00, step_dn} + 1'b1) : {2'b00, step_up});

	always_comb begin
		if (app[PROD_W-FRAC_BITS+2])
			app_w = app + {{(PROD_W-FRAC_BITS+3-CFG_W){1'b0}}, box_length};
		else if (app >= {{(PROD_W-FRAC_BITS+3-CFG_W){1'b0}}, box_length})
			app_w = app - {{(PROD_W-FRAC_BITS+3-CFG_W){1'b0}}, box_length};
		else
			app_w = app;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			new_pos <= mode_s5 ? pos_s5 : app_w[POS_W-1:0];
			new_vel <= vel_s5;
		end
	end
endmodule

@@ rtl/velocity_verlet_particle_update_core.sv @@
// Velocity Verlet particle update core: three coordinate lanes merged into one result register.
// Each lane holds a 33-stage quotient pipeline.
// Throughput one particle per cycle; the whole pipeline holds while a result waits.
// Asynchronous active-low reset clears valid flags and restores time_step and box_length.
// Depends on vv_pkg, vv_lane and vv_div.
module velocity_verlet_particle_update_core import vv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic              cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              mode,
	input  logic [POS_W-1:0]  pos_x,
	input  logic [POS_W-1:0]  pos_y,
	input  logic [POS_W-1:0]  pos_z,
	input  logic [VAL_W-1:0]  vel_x,
	input  logic [VAL_W-1:0]  vel_y,
	input  logic [VAL_W-1:0]  vel_z,
	input  logic [VAL_W-1:0]  force_x,
	input  logic [VAL_W-1:0]  force_y,
	input  logic [VAL_W-1:0]  force_z,
	input  logic [VAL_W-1:0]  particle_mass,
	input  logic              last_particle,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [POS_W-1:0]  new_pos_x,
	output logic [POS_W-1:0]  new_pos_y,
	output logic [POS_W-1:0]  new_pos_z,
	output logic [VAL_W-1:0]  new_vel_x,
	output logic [VAL_W-1:0]  new_vel_y,
	output logic [VAL_W-1:0]  new_vel_z,
	output logic              last_out
);
	logic [CFG_W-1:0]    time_step_q, box_length_q;
	logic [LANE_LAT-1:0] vld_q, last_q;
	logic                out_valid_q, en;
	logic [POS_W-1:0]    lpos [0:NUM_LANES-1];
	logic [VAL_W-1:0]    lvel [0:NUM_LANES-1];
	logic [POS_W-1:0]    ipos [0:NUM_LANES-1];
	logic [VAL_W-1:0]    ivel [0:NUM_LANES-1];
	logic [VAL_W-1:0]    ifrc [0:NUM_LANES-1];

	assign en = !out_valid_q || out_ready;
	assign in_ready = en;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q  <= TIME_STEP_RST;
			box_length_q <= BOX_LENGTH_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_TIME_STEP:  time_step_q  <= cfg_data;
				REG_BOX_LENGTH: box_length_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q       <= {vld_q[LANE_LAT-2:0], in_valid};
			out_valid_q <= vld_q[LANE_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) last_q <= {last_q[LANE_LAT-2:0], last_particle};
	end

	assign ipos[0] = pos_x;   assign ipos[1] = pos_y;   assign ipos[2] = pos_z;
	assign ivel[0] = vel_x;   assign ivel[1] = vel_y;   assign ivel[2] = vel_z;
	assign ifrc[0] = force_x; assign ifrc[1] = force_y; assign ifrc[2] = force_z;

	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		vv_lane u_lane (
			.clk(clk), .en(en), .time_step(time_step_q), .box_length(box_length_q),
			.mode(mode), .pos(ipos[l]), .vel(ivel[l]), .frc(ifrc[l]),
			.mass(particle_mass), .new_pos(lpos[l]), .new_vel(lvel[l])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			new_pos_x <= lpos[0]; new_pos_y <= lpos[1]; new_pos_z <= lpos[2];
			new_vel_x <= lvel[0]; new_vel_y <= lvel[1]; new_vel_z <= lvel[2];
			last_out  <= last_q[LANE_LAT-1];
		end
	end

`ifndef SYNTHESIS
	a_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_q[LANE_LAT-1]) |=> out_valid_q) else $error("result lost at merge");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> $stable(vld_q)) else $error("pipeline moved on stall");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_ready) |-> (out_valid_q && !out_ready)) else $error("request refused while free");
`endif
endmodule
